[src/smta_pkg.sv]
// Shared constants and types of the sliding median threshold alert block.
package smta_pkg;

	// Default window depth and sample width
	localparam int MAX_WINDOW_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed field widths
	localparam int CFG_BITS   = 9;
	localparam int COUNT_BITS = 32;

	// Reset value of the window length register
	localparam logic [CFG_BITS-1:0] WINDOW_LENGTH_RST = CFG_BITS'(1);

	// Controls broadcast to every cell of the sorted chain
	typedef struct packed {
		logic upd;   // apply one request to the chain
		logic clr;   // empty the window
		logic full;  // window full: drop the oldest while inserting
	} cell_ctrl_t;

endpackage

[src/smta_if.sv]
// Valid/ready channels for incoming samples and outgoing alert results.
interface smta_in_if #(
	parameter int SAMPLE_BITS = smta_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface smta_out_if #(
	parameter int SAMPLE_BITS = smta_pkg::SAMPLE_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic                              alert;
	logic [SAMPLE_BITS:0]              double_median;
	logic [smta_pkg::COUNT_BITS-1:0]   alert_total;

	modport source (output valid, output alert, output double_median, output alert_total,
		input ready);
	modport sink (input valid, input alert, input double_median, input alert_total,
		output ready);
endinterface

[src/smta_cell.sv]
// One cell of the sorted chain: holds one window value and its valid flag.
module smta_cell #(
	parameter int SAMPLE_BITS = smta_pkg::SAMPLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  smta_pkg::cell_ctrl_t    ctrl,
	input  logic [SAMPLE_BITS-1:0]  smp,
	input  logic [SAMPLE_BITS-1:0]  old,
	input  logic [SAMPLE_BITS-1:0]  right_val,
	input  logic                    right_vld,
	input  logic [SAMPLE_BITS-1:0]  left_w,
	input  logic                    left_wvld,
	input  logic                    left_a,
	output logic [SAMPLE_BITS-1:0]  val,
	output logic                    vld,
	output logic [SAMPLE_BITS-1:0]  w,
	output logic                    wvld,
	output logic                    a
);

	logic [SAMPLE_BITS-1:0] val_q;
	logic                   vld_q;
	logic                   rm_past;

	// At or past the removed entry: the first entry equal to the oldest sample
	assign rm_past = ctrl.full && vld_q && (val_q >= old);

	// Content of this place once the oldest sample has left the list
	assign w    = rm_past ? right_val : val_q;
	assign wvld = ctrl.full ? right_vld : vld_q;

	// At or past the insertion place of the new sample
	assign a = !wvld || (w >= smp);

	assign val = val_q;
	assign vld = vld_q;

	// Take the left neighbour, the new sample, or hold the compacted value
	always_ff @(posedge clk) begin
		if (ctrl.upd) begin
			if (left_a) begin
				val_q <= left_w;
			end else if (a) begin
				val_q <= smp;
			end else begin
				val_q <= w;
			end
		end
	end

	// Track occupancy; clear on reset and on a new window length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.clr) begin
			vld_q <= 1'b0;
		end else if (ctrl.upd) begin
			if (left_a) begin
				vld_q <= left_wvld;
			end else if (a) begin
				vld_q <= 1'b1;
			end else begin
				vld_q <= wvld;
			end
		end
	end

endmodule

[src/smta_chain.sv]
// Row of sorted cells with registered read-out of the two middle entries.
module smta_chain #(
	parameter int MAX_WINDOW  = smta_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = smta_pkg::SAMPLE_BITS_DEF,
	localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  smta_pkg::cell_ctrl_t    ctrl,
	input  logic [SAMPLE_BITS-1:0]  smp,
	input  logic [SAMPLE_BITS-1:0]  old,
	input  logic [PW-1:0]           mid_idx,
	input  logic [PW-1:0]           lo_idx,
	output logic [SAMPLE_BITS-1:0]  med_hi_q,
	output logic [SAMPLE_BITS-1:0]  med_lo_q
);

	logic [SAMPLE_BITS-1:0] vals  [MAX_WINDOW];
	logic                   vlds  [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] ws    [MAX_WINDOW];
	logic                   wvlds [MAX_WINDOW];
	logic                   as    [MAX_WINDOW];

	// Link each cell to its neighbours; the ends see empty places
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic [SAMPLE_BITS-1:0] r_val;
		logic                   r_vld;
		logic [SAMPLE_BITS-1:0] l_w;
		logic                   l_wvld;
		logic                   l_a;

		if (i == MAX_WINDOW - 1) begin : g_last
			assign r_val = '0;
			assign r_vld = 1'b0;
		end else begin : g_mid
			assign r_val = vals[i+1];
			assign r_vld = vlds[i+1];
		end

		if (i == 0) begin : g_first
			assign l_w    = '0;
			assign l_wvld = 1'b0;
			assign l_a    = 1'b0;
		end else begin : g_rest
			assign l_w    = ws[i-1];
			assign l_wvld = wvlds[i-1];
			assign l_a    = as[i-1];
		end

		smta_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.smp       (smp),
			.old       (old),
			.right_val (r_val),
			.right_vld (r_vld),
			.left_w    (l_w),
			.left_wvld (l_wvld),
			.left_a    (l_a),
			.val       (vals[i]),
			.vld       (vlds[i]),
			.w         (ws[i]),
			.wvld      (wvlds[i]),
			.a         (as[i])
		);
	end

	// Register the two middle entries of the current window
	always_ff @(posedge clk) begin
		med_hi_q <= vals[mid_idx];
		med_lo_q <= vals[lo_idx];
	end

endmodule

[src/sliding_median_threshold_alert.sv]
// Top level: sliding window median threshold alert over a chain of sorted cells.
//
//  channel    dir  handshake      payload
//  samples    in   valid / ready  sample
//  results    out  valid / ready  alert, double_median, alert_total
//  cfg        in   cfg_we         cfg_wdata (window_length)
//
// Requests are spaced by a busy state: the cell chain updates at the accepting edge,
// and the next cycle reloads the oldest sample from the history RAM and the
// two middle entries of the chain, which the following request compares with.
// Reset (arst_n low) empties the window, sets the window length to 1 and
// clears the alert count. A stalled result holds in the output register; a
// new request is taken only once that register is free or being emptied.
module sliding_median_threshold_alert #(
	parameter int MAX_WINDOW  = smta_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = smta_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [smta_pkg::CFG_BITS-1:0]   cfg_wdata,
	smta_in_if.sink                         samples,
	smta_out_if.source                      results
);

	localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LW = $clog2(MAX_WINDOW + 1);
	localparam int CB = smta_pkg::COUNT_BITS;

	logic [smta_pkg::CFG_BITS-1:0] wl_q;
	logic [LW-1:0]                 len;
	logic [LW-1:0]                 fill_q;
	logic [PW-1:0]                 slot_q;
	logic                          busy_q;
	logic                          full;
	logic                          accept;
	logic [SAMPLE_BITS-1:0]        hist [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0]        old_q;
	logic [PW-1:0]                 mid_idx;
	logic [PW-1:0]                 lo_idx;
	logic [SAMPLE_BITS-1:0]        med_hi_q;
	logic [SAMPLE_BITS-1:0]        med_lo_q;
	logic [SAMPLE_BITS:0]          dm;
	logic                          alert;
	logic [CB-1:0]                 cnt_q;
	logic [CB-1:0]                 cnt_nxt;
	logic                          ovld_q;
	logic                          oalert_q;
	logic [SAMPLE_BITS:0]          odm_q;
	logic [CB-1:0]                 ototal_q;
	smta_pkg::cell_ctrl_t          ctrl;

	// Clamp the window length to 1 .. MAX_WINDOW
	always_comb begin
		if (wl_q == '0) begin
			len = LW'(1);
		end else if (32'(wl_q) > 32'(MAX_WINDOW)) begin
			len = LW'(MAX_WINDOW);
		end else begin
			len = LW'(wl_q);
		end
	end

	assign full   = (fill_q >= len);
	assign accept = samples.valid && samples.ready;

	// Take a request when idle and the result register can move on
	assign samples.ready = !busy_q && (!ovld_q || results.ready);

	// Middle places of the sorted window
	assign mid_idx = PW'(len >> 1);
	assign lo_idx  = len[0] ? mid_idx : PW'((len >> 1) - LW'(1));

	// Compare with twice the median
	assign dm      = {1'b0, med_hi_q} + {1'b0, med_lo_q};
	assign alert   = ({1'b0, samples.sample} >= dm);
	assign cnt_nxt = (alert && (cnt_q != '1)) ? cnt_q + CB'(1) : cnt_q;

	assign ctrl.upd  = accept;
	assign ctrl.clr  = cfg_we;
	assign ctrl.full = full;

	smta_chain #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.smp      (samples.sample),
		.old      (old_q),
		.mid_idx  (mid_idx),
		.lo_idx   (lo_idx),
		.med_hi_q (med_hi_q),
		.med_lo_q (med_lo_q)
	);

	// Store the arrival ring and read the oldest sample ahead of the next request
	always_ff @(posedge clk) begin
		if (accept) begin
			hist[slot_q] <= samples.sample;
		end
		old_q <= hist[slot_q];
	end

	// Window length, fill level, ring pointer and request spacing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= smta_pkg::WINDOW_LENGTH_RST;
			fill_q <= '0;
			slot_q <= '0;
			busy_q <= 1'b0;
		end else begin
			busy_q <= accept;
			if (cfg_we) begin
				wl_q   <= cfg_wdata;
				fill_q <= '0;
				slot_q <= '0;
			end else if (accept) begin
				if (!full) begin
					fill_q <= fill_q + LW'(1);
				end
				if (LW'(slot_q) + LW'(1) == len) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + PW'(1);
				end
			end
		end
	end

	// Saturating alert count, kept across window length changes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept && full) begin
			cnt_q <= cnt_nxt;
		end
	end

	// Result register: load on a compared sample, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (accept && full) begin
			ovld_q <= 1'b1;
		end else if (results.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && full) begin
			oalert_q <= alert;
			odm_q    <= dm;
			ototal_q <= cnt_nxt;
		end
	end

	assign results.valid         = ovld_q;
	assign results.alert         = oalert_q;
	assign results.double_median = odm_q;
	assign results.alert_total   = ototal_q;

endmodule

[tb/sv/sliding_median_threshold_alert_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the sliding median threshold alert block.
module sliding_median_threshold_alert_tb;

	import smta_pkg::*;

	localparam int SB         = SAMPLE_BITS_DEF;
	localparam int MW         = MAX_WINDOW_DEF;
	localparam int QUIET_MAX  = 2000;
	localparam int SETTLE_CYC = 6;
	localparam int RANDOM_N   = 1600;

	typedef struct {
		logic [SB-1:0] value;
		bit            drain;  // hold the request until all results are back
	} backlog_t;

	typedef struct {
		logic                  alert;
		logic [SB:0]           dmed;
		logic [COUNT_BITS-1:0] total;
	} alert_rec_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_BITS-1:0] cfg_wdata;

	smta_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
	smta_out_if #(.SAMPLE_BITS(SB)) out_ch ();

	sliding_median_threshold_alert #(
		.MAX_WINDOW(MW),
		.SAMPLE_BITS(SB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.samples(in_ch),
		.results(out_ch)
	);

	always #10 clk = ~clk;

	// Predicted window state
	logic [CFG_BITS-1:0]   window_reg = WINDOW_LENGTH_RST;
	logic [SB-1:0]         ordered_win [MW];
	logic [SB-1:0]         arrival_ring [MW];
	int                    ring_head = 0;
	int                    held = 0;
	logic [COUNT_BITS-1:0] alert_tally = '0;

	backlog_t   sample_backlog [$];
	alert_rec_t due_results [$];

	int  errors = 0;
	int  quiet_cycles = 0;
	bit  sample_fire = 1'b0;
	bit  result_fire = 1'b0;
	int  gap_left = 0;
	int  stall_left = 0;
	bit  in_calm = 1'b0;
	bit  out_calm = 1'b0;

	task automatic note_error(input string msg);
		$display("sliding_median_threshold_alert_tb: mismatch: %s", msg);
		errors++;
	endtask

	function automatic int active_length();
		if (window_reg == 0)
			return 1;
		if (window_reg > MW)
			return MW;
		return int'(window_reg);
	endfunction

	// Insert v into the first n ascending entries
	function automatic void order_insert(input int n, input logic [SB-1:0] v);
		int pos;
		pos = 0;
		if (n >= MW)
			n = MW - 1;
		while (pos < n && ordered_win[pos] < v)
			pos++;
		for (int k = n; k > pos; k--)
			ordered_win[k] = ordered_win[k-1];
		ordered_win[pos] = v;
	endfunction

	// Drop the first entry equal to v from the first n entries
	function automatic void order_remove(input int n, input logic [SB-1:0] v);
		int pos;
		pos = 0;
		if (n == 0)
			return;
		while (pos < n && ordered_win[pos] != v)
			pos++;
		if (pos >= n)
			pos = n - 1;
		for (int k = pos; k + 1 < n; k++)
			ordered_win[k] = ordered_win[k+1];
	endfunction

	// Advance the window by one sample and queue the result it causes
	function automatic void median_step(input logic [SB-1:0] s);
		int         len;
		int         slot;
		int         mid;
		alert_rec_t rec;
		len  = active_length();
		slot = ring_head % len;
		if (held < len) begin
			order_insert(held, s);
			arrival_ring[slot] = s;
			held++;
			ring_head = (slot + 1) % len;
			return;
		end
		mid = len / 2;
		if (len % 2)
			rec.dmed = {ordered_win[mid], 1'b0};
		else
			rec.dmed = (SB+1)'(ordered_win[mid]) + (SB+1)'(ordered_win[mid-1]);
		rec.alert = ({1'b0, s} >= rec.dmed);
		if (rec.alert && alert_tally != '1)
			alert_tally++;
		rec.total = alert_tally;
		order_remove(len, arrival_ring[slot]);
		order_insert(len - 1, s);
		arrival_ring[slot] = s;
		ring_head = (slot + 1) % len;
		due_results.insert(due_results.size(), rec);
	endfunction

	// Sample source: raise a request after its gap, drop it once taken
	always @(negedge clk) begin
		bit       nxt_valid;
		backlog_t item;
		if (!arst_n) begin
			in_ch.valid  <= 1'b0;
			in_ch.sample <= '0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				in_calm = ~in_calm;
			nxt_valid = in_ch.valid;
			if (in_ch.valid && sample_fire)
				nxt_valid = 1'b0;
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (sample_backlog.size() > 0 &&
						!(sample_backlog[0].drain && due_results.size() > 0)) begin
					item = sample_backlog.pop_front();
					in_ch.sample <= item.value;
					nxt_valid = 1'b1;
					gap_left = in_calm ? 0 : $urandom_range(0, 9);
				end
			end
			in_ch.valid <= nxt_valid;
		end
	end

	// Result sink: stall for a random count after each accepted result
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				out_calm = ~out_calm;
			if (result_fire)
				stall_left = out_calm ? 0 : $urandom_range(0, 9);
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: check results, predict accepted requests, watch for a hang
	always @(posedge clk) begin
		alert_rec_t want;
		sample_fire <= in_ch.valid && in_ch.ready;
		result_fire <= out_ch.valid && out_ch.ready;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (due_results.size() == 0) begin
					note_error("result with none expected");
				end else begin
					want = due_results.pop_front();
					if (out_ch.alert !== want.alert)
						note_error($sformatf("alert got %0d want %0d",
							out_ch.alert, want.alert));
					if (out_ch.double_median !== want.dmed)
						note_error($sformatf("double_median got %0d want %0d",
							out_ch.double_median, want.dmed));
					if (out_ch.alert_total !== want.total)
						note_error($sformatf("alert_total got %0d want %0d",
							out_ch.alert_total, want.total));
				end
			end
			if (in_ch.valid && in_ch.ready)
				median_step(in_ch.sample);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("sliding_median_threshold_alert_tb: done, errors");
				$finish;
			end
		end
	end

	task automatic queue_sample(input logic [SB-1:0] v, input bit drain = 1'b0);
		backlog_t item;
		item.value = v;
		item.drain = drain;
		sample_backlog.insert(sample_backlog.size(), item);
	endtask

	// Wait for the source to empty and every result to return, then let the block rest
	task automatic settle();
		@(posedge clk);
		while (sample_backlog.size() > 0 || in_ch.valid || due_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Write the window length; the write also empties the predicted window
	task automatic set_window(input logic [CFG_BITS-1:0] len);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		window_reg = len;
		held       = 0;
		ring_head  = 0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SB-1:0] draw_sample(input int base);
		int v;
		case ($urandom_range(0, 7))
			0, 1:    v = $urandom_range(0, (1 << SB) - 1);
			2, 3:    v = $urandom_range(0, 7);
			7:       v = 2 * base + $urandom_range(0, 3) - 1;
			default: v = base - base / 8 + $urandom_range(0, base / 4);
		endcase
		if (v < 0)
			v = 0;
		if (v > (1 << SB) - 1)
			v = (1 << SB) - 1;
		return SB'(v);
	endfunction

	initial begin
		int            random_total;
		int            len;
		int            eff;
		int            count;
		int            base;
		logic [SB-1:0] corner_vals [10];
		random_total = 0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_ch.valid  = 1'b0;
		in_ch.sample = '0;
		out_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset length of one: extremes, zero median, equal to double
		corner_vals = '{16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF,
			16'd1, 16'd2, 16'h8000, 16'hFFFF};
		foreach (corner_vals[i])
			queue_sample(corner_vals[i]);
		settle();

		// Even length: median as the sum of two middle entries
		set_window(CFG_BITS'(2));
		queue_sample(16'h8000);
		queue_sample(16'h7FFF);
		queue_sample(16'hFFFF);
		queue_sample(16'd0);
		queue_sample(16'd7);
		queue_sample(16'd7);
		queue_sample(16'd7);
		settle();

		// Zero length behaves as one
		set_window(CFG_BITS'(0));
		queue_sample(16'd5);
		queue_sample(16'd10);
		queue_sample(16'd9);
		queue_sample(16'd0);
		settle();

		// Odd length with repeated values; hold one request until drained
		set_window(CFG_BITS'(3));
		queue_sample(16'd4);
		queue_sample(16'd4);
		queue_sample(16'd4);
		queue_sample(16'd8, 1'b1);
		queue_sample(16'd8);
		queue_sample(16'd3);
		settle();

		// Random phases: lengths above the maximum and at it first, then mostly short
		while (random_total < RANDOM_N) begin
			if (random_total == 0)
				len = (1 << CFG_BITS) - 1;
			else if (random_total < 400)
				len = MW;
			else begin
				case ($urandom_range(0, 11))
					0:       len = $urandom_range(MW, (1 << CFG_BITS) - 1);
					1:       len = 0;
					2:       len = $urandom_range(13, 64);
					default: len = $urandom_range(1, 12);
				endcase
			end
			set_window(CFG_BITS'(len));
			eff   = (len == 0) ? 1 : (len > MW ? MW : len);
			count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, eff) :
				eff + $urandom_range(20, 100);
			base  = $urandom_range(0, 1) ? $urandom_range(0, 40000) : $urandom_range(0, 60);
			repeat (count)
				queue_sample(draw_sample(base), $urandom_range(0, 59) == 0);
			random_total += count;
			settle();
		end

		if (errors == 0)
			$display("sliding_median_threshold_alert_tb: done, clean");
		else
			$display("sliding_median_threshold_alert_tb: done, errors");
		$finish;
	end

endmodule

[files.f]
src/smta_pkg.sv
src/smta_if.sv
src/smta_cell.sv
src/smta_chain.sv
src/sliding_median_threshold_alert.sv
tb/sv/sliding_median_threshold_alert_tb.sv
